FILE: sv/sps_pkg.sv
// Package for the semitone pitch-shift resampler: register codes, types and the ratio table.
package sps_pkg;

  // Configuration register indexes
  localparam logic CFG_SEMITONE_SHIFT = 1'b0;
  localparam logic CFG_OUTPUT_LIMIT   = 1'b1;

  localparam int SAMPLE_W  = 16;
  localparam int LIMIT_W   = 16;
  localparam int SHIFT_W   = 5;
  localparam int RATIO_LUT_W = 18;
  localparam int INT_W     = 18;   // integer bits of the read position

  localparam logic signed [SHIFT_W-1:0] SHIFT_MIN = -5'sd12;
  localparam logic signed [SHIFT_W-1:0] SHIFT_MAX = 5'sd12;
  localparam logic [SHIFT_W-1:0]        SHIFT_BIAS = 5'd12;

  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 16'hFFFF;

  // One pending result beat
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                run_last;
    logic                limit_hit;
  } res_t;

  // 2^(n/12) in Q2.16, indexed by n+12
  function automatic logic [RATIO_LUT_W-1:0] ratio_lut(input logic [SHIFT_W-1:0] sel);
    logic [RATIO_LUT_W-1:0] r;
    unique case (sel)
      5'd0:  r = 18'd32768;
      5'd1:  r = 18'd34716;
      5'd2:  r = 18'd36780;
      5'd3:  r = 18'd38967;
      5'd4:  r = 18'd41285;
      5'd5:  r = 18'd43740;
      5'd6:  r = 18'd46341;
      5'd7:  r = 18'd49097;
      5'd8:  r = 18'd52016;
      5'd9:  r = 18'd55109;
      5'd10: r = 18'd58386;
      5'd11: r = 18'd61858;
      5'd12: r = 18'd65536;
      5'd13: r = 18'd69433;
      5'd14: r = 18'd73562;
      5'd15: r = 18'd77936;
      5'd16: r = 18'd82570;
      5'd17: r = 18'd87480;
      5'd18: r = 18'd92682;
      5'd19: r = 18'd98193;
      5'd20: r = 18'd104032;
      5'd21: r = 18'd110218;
      5'd22: r = 18'd116772;
      5'd23: r = 18'd123715;
      5'd24: r = 18'd131072;
      default: r = 18'd65536;
    endcase
    return r;
  endfunction

endpackage

FILE: sv/semitone_pitch_shift_resampler.sv
// Top level of the nearest-neighbor semitone pitch-shift resampler.
//
// Takes one 16-bit sample beat per cycle while in_tready is high and emits zero, one or
// two copies of it, stepping a fixed-point read position by 2^(n/12) per output beat
// (n = the configured shift, clamped to -12..+12). All results of a sample are worked out
// in the cycle the sample is accepted (two chained position adds) and parked in a
// two-entry output queue, so a sample is taken every cycle while each yields at most one
// beat and out_tready stays high; a sample that yields two beats holds the port until
// both leave: at most one beat per sample at pitch-up or unity, up to two at pitch-down.
// in_tready is high when the queue is empty, or holds one beat that leaves in the same
// cycle. tlast on the input ends a clip: position and counters return to zero after its
// outputs. Outputs stop once output_limit beats have been produced in a clip; samples
// past MAX_CLIP_SAMPLES in one clip give none. Register writes apply from the next sample.
module semitone_pitch_shift_resampler #(
  parameter int FRACTION_BITS    = 16,
  parameter int MAX_CLIP_SAMPLES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_wdata,
  // input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] in_sample
  input  logic        in_tlast,   // clip_end
  // output stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [15:0] out_sample
  output logic        out_tlast,  // run_last
  output logic        out_tuser   // [0] limit_hit
);

  localparam int POS_W = FRACTION_BITS + sps_pkg::INT_W;
  localparam int RAT_W = FRACTION_BITS + 2;
  localparam int RSH   = 24 - FRACTION_BITS;
  localparam int IDX_W = $clog2(MAX_CLIP_SAMPLES + 1);
  localparam logic [IDX_W-1:0] IDX_MAX = IDX_W'(MAX_CLIP_SAMPLES);

  // config registers
  logic signed [sps_pkg::SHIFT_W-1:0] shift_r;
  logic [sps_pkg::LIMIT_W-1:0]        limit_r;

  // clip state
  logic [POS_W-1:0]            pos_r, pos_nxt;
  logic [IDX_W-1:0]            idx_r, idx_nxt;
  logic [sps_pkg::LIMIT_W-1:0] prod_r, prod_nxt;

  // output queue, slot 0 is the head
  sps_pkg::res_t slot0_r, slot1_r;
  logic [1:0]    cnt_r;

  logic in_acc, out_acc;
  assign in_acc  = in_tvalid & in_tready;
  assign out_acc = out_tvalid & out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      shift_r <= '0;
      limit_r <= sps_pkg::LIMIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sps_pkg::CFG_SEMITONE_SHIFT: shift_r <= cfg_wdata[sps_pkg::SHIFT_W-1:0];
        sps_pkg::CFG_OUTPUT_LIMIT:   limit_r <= cfg_wdata[sps_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  // step ratio: clamp, table, rescale to FRACTION_BITS
  logic signed [sps_pkg::SHIFT_W-1:0] shift_cl;
  logic [sps_pkg::SHIFT_W-1:0]        tab_sel;
  logic [sps_pkg::RATIO_LUT_W+7:0]    rat_wide;
  logic [RAT_W-1:0]                   ratio;
  logic [POS_W-1:0]                   ratio_ext;

  always_comb begin
    priority if (shift_r < sps_pkg::SHIFT_MIN) shift_cl = sps_pkg::SHIFT_MIN;
    else if (shift_r > sps_pkg::SHIFT_MAX)     shift_cl = sps_pkg::SHIFT_MAX;
    else                                       shift_cl = shift_r;
  end

  assign tab_sel   = shift_cl + sps_pkg::SHIFT_BIAS;
  assign rat_wide  = {sps_pkg::ratio_lut(tab_sel), 8'd0} >> RSH;
  assign ratio     = rat_wide[RAT_W-1:0];
  assign ratio_ext = {{(POS_W-RAT_W){1'b0}}, ratio};

  // both candidate outputs of this sample
  logic [sps_pkg::INT_W-1:0]   idx_ext;
  logic [POS_W-1:0]            pos1, pos2;
  logic [sps_pkg::LIMIT_W-1:0] prod1, prod2;
  logic                        in_range, c0, c1, hit0, hit1;

  assign idx_ext  = {{(sps_pkg::INT_W-IDX_W){1'b0}}, idx_r};
  assign in_range = idx_r < IDX_MAX;
  assign pos1     = pos_r + ratio_ext;
  assign pos2     = pos1 + ratio_ext;
  assign prod1    = prod_r + 1'b1;
  assign prod2    = prod_r + 2'd2;

  assign c0   = in_range && (pos_r[POS_W-1:FRACTION_BITS] == idx_ext) && (prod_r < limit_r);
  assign c1   = c0 && (pos1[POS_W-1:FRACTION_BITS] == idx_ext) && (prod1 < limit_r);
  assign hit0 = prod1 == limit_r;
  assign hit1 = prod2 == limit_r;

  always_comb begin
    pos_nxt  = pos_r;
    idx_nxt  = idx_r;
    prod_nxt = prod_r;
    if (in_tlast) begin
      pos_nxt  = '0;
      idx_nxt  = '0;
      prod_nxt = '0;
    end else begin
      if (in_range) idx_nxt = idx_r + 1'b1;
      if (c1) begin
        pos_nxt  = pos2;
        prod_nxt = prod2;
      end else if (c0) begin
        pos_nxt  = pos1;
        prod_nxt = prod1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= '0;
      idx_r  <= '0;
      prod_r <= '0;
    end else if (in_acc) begin
      pos_r  <= pos_nxt;
      idx_r  <= idx_nxt;
      prod_r <= prod_nxt;
    end
  end

  // queue: accept only when it will be empty after this cycle's pop
  assign in_tready = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (in_acc) begin
      cnt_r <= {1'b0, c0} + {1'b0, c1};
    end else if (out_acc) begin
      cnt_r <= cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      slot0_r <= '{sample: in_tdata, run_last: ~c1, limit_hit: hit0};
      slot1_r <= '{sample: in_tdata, run_last: 1'b1, limit_hit: hit1};
    end else if (out_acc) begin
      slot0_r <= slot1_r;
    end
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = slot0_r.sample;
  assign out_tlast  = slot0_r.run_last;
  assign out_tuser  = slot0_r.limit_hit;

`ifndef SYNTH
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n) cnt_r != 2'd3)
    else $error("output queue overfilled");

  a_acc_drained: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> (cnt_r == 2'd0) || (cnt_r == 2'd1 && out_acc))
    else $error("sample accepted over pending beats");

  a_clip_clear: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> pos_r == '0 && idx_r == '0 && prod_r == '0)
    else $error("clip state not cleared after clip end");

  a_idx_sat: assert property (@(posedge clk) disable iff (!rst_n) idx_r <= IDX_MAX)
    else $error("input index past saturation");
`endif

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for the semitone pitch-shift resampler stream.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int FRAC_BITS = 16;
  localparam int CLIP_CAP  = 65536;   // samples per clip that can still give output
  localparam int HOLD_LEN  = 300;     // long receiver hold-off, in cycles

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = sps_pkg::CFG_SEMITONE_SHIFT;
  logic [15:0] cfg_wdata = '0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [15:0] in_tdata = '0;    // [15:0] in_sample
  logic        in_tlast = 1'b0;  // clip_end
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [15:0] out_tdata;        // [15:0] out_sample
  logic        out_tlast;        // run_last
  logic        out_tuser;        // [0] limit_hit

  // Shadow state of the resampler
  logic [63:0]             rd_pos;
  int unsigned             clip_idx;
  logic [15:0]             n_made;
  logic signed [4:0]       cur_shift;
  logic [15:0]             cur_limit;
  sps_pkg::res_t           due_beats[$];   // output beats still owed, oldest first

  int  fail_count    = 0;
  int  items_sent    = 0;
  int  beats_checked = 0;
  int  reg_writes    = 0;
  bit  idle_on       = 1'b1;
  int  hold_asks     = 0;

  semitone_pitch_shift_resampler u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tlast (out_tlast),
    .out_tuser (out_tuser)
  );

  always #10 clk = ~clk;

  // Safety net: far beyond the slowest legal run
  initial begin
    #30_000_000;
    $display("tb_top: FAIL");
    $finish;
  end

  // 2^(n/12) in Q16.16; shifts outside -12..12 clamp to the ends
  function automatic logic [63:0] step_q16(logic signed [4:0] n);
    int k;
    k = n;
    if (k < -12) k = -12;
    if (k > 12) k = 12;
    case (k)
      -12: return 64'd32768;
      -11: return 64'd34716;
      -10: return 64'd36780;
      -9:  return 64'd38967;
      -8:  return 64'd41285;
      -7:  return 64'd43740;
      -6:  return 64'd46341;
      -5:  return 64'd49097;
      -4:  return 64'd52016;
      -3:  return 64'd55109;
      -2:  return 64'd58386;
      -1:  return 64'd61858;
      0:   return 64'd65536;
      1:   return 64'd69433;
      2:   return 64'd73562;
      3:   return 64'd77936;
      4:   return 64'd82570;
      5:   return 64'd87480;
      6:   return 64'd92682;
      7:   return 64'd98193;
      8:   return 64'd104032;
      9:   return 64'd110218;
      10:  return 64'd116772;
      11:  return 64'd123715;
      default: return 64'd131072;
    endcase
  endfunction

  // Advance the shadow state by one sample and queue the beats it owes.
  function automatic void resample_sample(logic [15:0] s, logic clip_end);
    logic [63:0]   ratio;
    int            cnt;
    sps_pkg::res_t b[2];
    ratio = step_q16(cur_shift);
    cnt = 0;
    if (clip_idx < CLIP_CAP) begin
      // every output whose position lands on this sample is a copy of it
      while (cnt < 2 && (rd_pos >> FRAC_BITS) == 64'(clip_idx) && n_made < cur_limit) begin
        n_made = n_made + 16'd1;
        rd_pos = rd_pos + ratio;
        b[cnt].sample    = s;
        b[cnt].run_last  = 1'b0;
        b[cnt].limit_hit = (n_made == cur_limit);
        cnt++;
      end
      if (cnt > 0) b[cnt-1].run_last = 1'b1;
      for (int i = 0; i < cnt; i++) due_beats.push_back(b[i]);
      clip_idx++;
    end
    if (clip_end) begin
      rd_pos   = '0;
      clip_idx = 0;
      n_made   = '0;
    end
  endfunction

  task automatic flag_error(string msg);
    if (fail_count < 10) $display("ERROR: %s", msg);
    fail_count++;
  endtask

  // Result checker: each accepted beat against the oldest owed one
  always @(posedge clk) begin
    sps_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (due_beats.size() == 0) begin
        flag_error($sformatf("unexpected beat sample %h last %b limit %b",
                             out_tdata, out_tlast, out_tuser));
      end else begin
        want = due_beats.pop_front();
        if (out_tdata !== want.sample || out_tlast !== want.run_last ||
            out_tuser !== want.limit_hit)
          flag_error($sformatf("beat %0d: exp sample %h last %b limit %b, got %h %b %b",
                               beats_checked, want.sample, want.run_last, want.limit_hit,
                               out_tdata, out_tlast, out_tuser));
        beats_checked++;
      end
    end
  end

  // Receiver: random stall bursts, plus a long hold-off when the test asks for one
  int holds_served = 0;
  int hold_left    = 0;
  int stall_left   = 0;
  always @(posedge clk) begin
    if (hold_asks != holds_served) begin
      holds_served <= hold_asks;
      hold_left    <= HOLD_LEN;
      out_tready   <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      stall_left <= $urandom_range(0, 12);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  // Offer one sample beat and wait for it to be taken.
  // tvalid is only dropped ahead of a gap, so back-to-back beats keep it high.
  task automatic send_sample(logic [15:0] s, logic clip_end);
    int gap;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 13);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= s;
    in_tlast  <= clip_end;
    do @(posedge clk); while (!in_tready);
    resample_sample(s, clip_end);
    items_sent++;
  endtask

  // Stop offering, wait for every owed beat, then let the pipe settle
  // (a sample that owes nothing may still be in flight).
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (due_beats.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  // Register writes happen only with the block idle
  task automatic write_reg(logic idx, logic [15:0] val);
    drain();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == sps_pkg::CFG_SEMITONE_SHIFT) cur_shift = val[4:0];
    else cur_limit = val;
    reg_writes++;
    @(posedge clk);
  endtask

  // Reset values: unity ratio, one copy per sample, full-scale samples
  task automatic test_reset_defaults();
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b0);
    send_sample(16'h0000, 1'b0);
    send_sample(16'hFFFF, 1'b1);
  endtask

  // Both ends of the shift range, and shift codes past them that clamp
  task automatic test_shift_extremes();
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h0014);  // -12: two beats per sample
    send_sample(16'h1234, 1'b0);
    send_sample(16'hEDCB, 1'b0);
    send_sample(16'h5555, 1'b1);
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h000C);  // +12: every other sample
    send_sample(16'hAAAA, 1'b0);
    send_sample(16'h0001, 1'b0);
    send_sample(16'hFFFE, 1'b1);
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'hFFF0);  // -16, upper bits ignored
    send_sample(16'h4000, 1'b0);
    send_sample(16'hC000, 1'b1);
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h000D);  // +13
    send_sample(16'h0F0F, 1'b0);
    send_sample(16'hF0F0, 1'b1);
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h000F);  // +15
    send_sample(16'h3C3C, 1'b0);
    send_sample(16'hC3C3, 1'b1);
  endtask

  // Zero limit, limit reached mid-sample, then a raise inside the same clip
  task automatic test_output_limit();
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h0000);
    write_reg(sps_pkg::CFG_OUTPUT_LIMIT, 16'd0);
    send_sample(16'h7FFF, 1'b0);
    send_sample(16'h8000, 1'b1);
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h0014);
    write_reg(sps_pkg::CFG_OUTPUT_LIMIT, 16'd3);
    send_sample(16'h1111, 1'b0);
    send_sample(16'h2222, 1'b0);
    send_sample(16'h3333, 1'b0);
    // position has fallen behind: the raise must not revive output
    write_reg(sps_pkg::CFG_OUTPUT_LIMIT, 16'd100);
    send_sample(16'h4444, 1'b0);
    send_sample(16'h5555, 1'b1);
    write_reg(sps_pkg::CFG_OUTPUT_LIMIT, 16'hFFFF);
  endtask

  // Shift change between two samples of one clip
  task automatic test_midclip_shift();
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h0000);
    send_sample(16'h0101, 1'b0);
    send_sample(16'h0202, 1'b0);
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h0014);
    send_sample(16'h0303, 1'b1);
  endtask

  // Receiver holds off for a long stretch while samples keep coming
  task automatic test_backpressure();
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h0014);
    idle_on = 1'b0;
    hold_asks++;
    for (int i = 0; i < 30; i++) send_sample(16'($urandom), i == 29);
    drain();
    idle_on = 1'b1;
  endtask

  // Random settings, each followed by a few clips of random samples
  task automatic test_random_clips(int target);
    int          start;
    int          k;
    int          clips;
    int          len;
    logic [15:0] w;
    logic        brk;
    start = items_sent;
    while (items_sent - start < target) begin
      if ($urandom_range(0, 3) == 0) begin
        w = 16'($urandom);                 // any code, clamped ones too
      end else begin
        k = int'($urandom_range(0, 24)) - 12;
        w = {11'($urandom), 5'(k)};
      end
      write_reg(sps_pkg::CFG_SEMITONE_SHIFT, w);
      case ($urandom_range(0, 5))
        0: w = 16'($urandom);
        1: w = 16'($urandom_range(0, 8));
        2: w = 16'($urandom_range(20, 80));
        default: w = 16'hFFFF;
      endcase
      write_reg(sps_pkg::CFG_OUTPUT_LIMIT, w);
      clips = $urandom_range(1, 3);
      for (int c = 0; c < clips; c++) begin
        len = $urandom_range(1, 40);
        // sometimes the clip is left open so the next settings land mid-clip
        brk = (c == clips - 1) && ($urandom_range(0, 4) == 0);
        for (int j = 0; j < len; j++) begin
          case ($urandom_range(0, 15))
            0: w = 16'h7FFF;
            1: w = 16'h8000;
            default: w = 16'($urandom);
          endcase
          send_sample(w, ((j == len - 1) && !brk) || ($urandom_range(0, 59) == 0));
        end
      end
    end
  endtask

  // One long clip at +12 (via code +15), no idling; then a short clip
  task automatic test_long_clip();
    write_reg(sps_pkg::CFG_SEMITONE_SHIFT, 16'h000F);
    write_reg(sps_pkg::CFG_OUTPUT_LIMIT, 16'hFFFF);
    idle_on = 1'b0;
    for (int i = 0; i < 200; i++) send_sample(16'($urandom), i == 199);
    for (int i = 0; i < 3; i++) send_sample(16'($urandom), i == 2);
    drain();
  endtask

  initial begin
    rd_pos    = '0;
    clip_idx  = 0;
    n_made    = '0;
    cur_shift = '0;
    cur_limit = sps_pkg::LIMIT_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_defaults();
    test_shift_extremes();
    test_output_limit();
    test_midclip_shift();
    test_backpressure();
    test_random_clips(1600);
    test_long_clip();

    $display("Run covered %0d samples, %0d output beats checked, %0d register writes.",
             items_sent, beats_checked, reg_writes);
    $display("Shifts -16..15, limits 0..65535, a receiver hold-off and a long unpaused clip.");
    if (fail_count == 0 && due_beats.size() == 0) begin
      $display("tb_top: PASS");
    end else begin
      $display("%0d mismatches, %0d beats never seen", fail_count, due_beats.size());
      $display("tb_top: FAIL");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/sps_pkg.sv
sv/semitone_pitch_shift_resampler.sv
verif/tb_top.sv
